// File: rtl/core/rsaf_pkg.sv
package rsaf_pkg;

	// Operating modes, encoded as they appear on the result's mode field.
	typedef enum logic [2:0] {
		MODE_WAIT   = 3'd0,
		MODE_SPIN   = 3'd1,
		MODE_GLOBAL = 3'd2,
		MODE_LOCAL  = 3'd3,
		MODE_ATTACK = 3'd4,
		MODE_ESCAPE = 3'd5,
		MODE_TURN   = 3'd6
	} mode_t;

	// Side where the target was last seen.
	typedef enum logic [1:0] {
		SIDE_LEFT   = 2'd0,
		SIDE_CENTER = 2'd1,
		SIDE_RIGHT  = 2'd2
	} side_t;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 10;
	localparam logic [CFG_INDEX_W-1:0] REG_DETECT_THRESHOLD   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY_TICKS  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SPIN_TICKS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_ESCAPE_TICKS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_TURN_TICKS  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_SCAN_TICKS   = 3'd5;

	// Register reset values.
	localparam logic [7:0] DETECT_THRESHOLD_RST   = 8'd80;
	localparam logic [9:0] START_DELAY_TICKS_RST  = 10'd750;
	localparam logic [7:0] INITIAL_SPIN_TICKS_RST = 8'd100;
	localparam logic [7:0] LINE_ESCAPE_TICKS_RST  = 8'd40;
	localparam logic [7:0] ESCAPE_TURN_TICKS_RST  = 8'd70;
	localparam logic [7:0] LOCAL_SCAN_TICKS_RST   = 8'd70;

	// Motor speed constants, signed; the global-scan pair is already negative.
	localparam logic signed [7:0] SPEED_SPIN         = 8'sd25;
	localparam logic signed [7:0] SPEED_ESCAPE       = 8'sd70;
	localparam logic signed [7:0] SPEED_TURN         = 8'sd20;
	localparam logic signed [7:0] SPEED_GLOBAL_LEFT  = -8'sd39;
	localparam logic signed [7:0] SPEED_GLOBAL_RIGHT = -8'sd40;
	localparam logic signed [7:0] SPEED_LOCAL        = 8'sd25;
	localparam logic signed [7:0] SPEED_CHASE_CENTER = 8'sd20;
	localparam logic signed [7:0] SPEED_CHASE_SIDE   = 8'sd15;

	// One pass of the control loop.
	typedef struct packed {
		logic       tick;
		logic [7:0] range_left_now;
		logic [7:0] range_center_now;
		logic [7:0] range_right_now;
		logic [7:0] range_left_prev;
		logic [7:0] range_center_prev;
		logic [7:0] range_right_prev;
		logic       line_seen;
	} item_t;

	// Result of one pass.
	typedef struct packed {
		logic              speed_valid;
		logic signed [7:0] left_speed;
		logic signed [7:0] right_speed;
		logic [2:0]        mode;
	} result_t;

endpackage

// File: rtl/core/robot_seek_attack_fsm_top.sv
// Mode controller of a small ring-fighting robot.
// Items arrive on the item channel (item_valid / item_ready), one per pass of
// the control loop; each carries the tick flag, current and previous range
// readings and the edge-line flag. Every item yields exactly one result on the
// result channel (result_valid / result_ready): speed_valid, the motor speed
// pair and the mode after the pass.
// An accepted item is held in the input register; the single-pass decision
// logic then writes the result register and the mode state together.
// Throughput is one item per cycle; it is set by the input register feeding
// the result register, which both advance in the same cycle whenever the
// result register is empty or being taken.
// When the receiver stalls, the result holds, the pending item waits in the
// input register and item_ready drops until the result is taken.
// The cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the six
// threshold and tick registers; it is always ready, indexes above five are
// ignored and data is truncated to the register width. Write it only while no
// item is in flight.
// Reset puts the registers at their defaults, the mode in wait, all tick
// counters at zero, the last side at center and both channels empty.
module robot_seek_attack_fsm_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  rsaf_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output rsaf_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rsaf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rsaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Configuration registers.
	logic [7:0] detect_threshold_q;
	logic [9:0] start_delay_ticks_q;
	logic [7:0] initial_spin_ticks_q;
	logic [7:0] line_escape_ticks_q;
	logic [7:0] escape_turn_ticks_q;
	logic [7:0] local_scan_ticks_q;

	// Controller state.
	rsaf_pkg::mode_t mode_q;
	rsaf_pkg::side_t side_q;
	logic [9:0]      start_count_q;
	logic [7:0]      turn_count_q;
	logic [7:0]      escape_count_q;
	logic [7:0]      local_count_q;

	// Pipeline registers.
	logic              valid_s1;
	rsaf_pkg::item_t   item_s1;
	logic              valid_s2;
	rsaf_pkg::result_t result_s2;

	// Next-state values of the decision logic.
	rsaf_pkg::mode_t   mode_d;
	rsaf_pkg::side_t   side_d;
	logic [9:0]        start_count_d;
	logic [7:0]        turn_count_d;
	logic [7:0]        escape_count_d;
	logic [7:0]        local_count_d;
	rsaf_pkg::result_t result_d;

	logic advance;
	logic ln, cn, rn, lp, cp, rp;
	logic pair_now, persist;

	// The input register moves on when the result slot is free or draining.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_threshold_q   <= rsaf_pkg::DETECT_THRESHOLD_RST;
			start_delay_ticks_q  <= rsaf_pkg::START_DELAY_TICKS_RST;
			initial_spin_ticks_q <= rsaf_pkg::INITIAL_SPIN_TICKS_RST;
			line_escape_ticks_q  <= rsaf_pkg::LINE_ESCAPE_TICKS_RST;
			escape_turn_ticks_q  <= rsaf_pkg::ESCAPE_TURN_TICKS_RST;
			local_scan_ticks_q   <= rsaf_pkg::LOCAL_SCAN_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rsaf_pkg::REG_DETECT_THRESHOLD:   detect_threshold_q   <= cfg_data[7:0];
				rsaf_pkg::REG_START_DELAY_TICKS:  start_delay_ticks_q  <= cfg_data;
				rsaf_pkg::REG_INITIAL_SPIN_TICKS: initial_spin_ticks_q <= cfg_data[7:0];
				rsaf_pkg::REG_LINE_ESCAPE_TICKS:  line_escape_ticks_q  <= cfg_data[7:0];
				rsaf_pkg::REG_ESCAPE_TURN_TICKS:  escape_turn_ticks_q  <= cfg_data[7:0];
				rsaf_pkg::REG_LOCAL_SCAN_TICKS:   local_scan_ticks_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Sensor sightings against the threshold.
	assign ln = item_s1.range_left_now    > detect_threshold_q;
	assign cn = item_s1.range_center_now  > detect_threshold_q;
	assign rn = item_s1.range_right_now   > detect_threshold_q;
	assign lp = item_s1.range_left_prev   > detect_threshold_q;
	assign cp = item_s1.range_center_prev > detect_threshold_q;
	assign rp = item_s1.range_right_prev  > detect_threshold_q;

	assign pair_now = (rn && cn) || (ln && cn);
	assign persist  = (rn && rp) || (ln && lp) || (cn && cp);

	// Mode decision for one pass.
	always_comb begin
		rsaf_pkg::mode_t   m;
		logic              cv;
		logic signed [7:0] cl;
		logic signed [7:0] cr;

		m              = mode_q;
		side_d         = side_q;
		start_count_d  = start_count_q;
		turn_count_d   = turn_count_q;
		escape_count_d = escape_count_q;
		local_count_d  = local_count_q;
		cv             = 1'b0;
		cl             = '0;
		cr             = '0;

		if (mode_q == rsaf_pkg::MODE_WAIT) begin
			if (item_s1.tick) begin
				start_count_d = start_count_q + 10'd1;
			end
			if (start_count_d >= start_delay_ticks_q) begin
				m = rsaf_pkg::MODE_SPIN;
			end
		end else if (mode_q == rsaf_pkg::MODE_SPIN) begin
			cv = 1'b1;
			cl = rsaf_pkg::SPEED_SPIN;
			cr = -rsaf_pkg::SPEED_SPIN;
			if (item_s1.tick) begin
				turn_count_d = turn_count_q + 8'd1;
				if (pair_now) begin
					m = rsaf_pkg::MODE_ATTACK;
				end
			end
			// The end of the spin overrides an attack chosen in the same pass.
			if (turn_count_d == initial_spin_ticks_q) begin
				turn_count_d = '0;
				m = rsaf_pkg::MODE_GLOBAL;
			end
		end else begin
			// Timed modes advance their counters first.
			if (item_s1.tick) begin
				case (mode_q)
					rsaf_pkg::MODE_ESCAPE: begin
						escape_count_d = escape_count_q + 8'd1;
						if (escape_count_d == line_escape_ticks_q) begin
							turn_count_d = '0;
							m = rsaf_pkg::MODE_TURN;
						end
					end
					rsaf_pkg::MODE_TURN: begin
						turn_count_d = turn_count_q + 8'd1;
						if (turn_count_d == escape_turn_ticks_q) begin
							m = rsaf_pkg::MODE_GLOBAL;
						end
					end
					rsaf_pkg::MODE_LOCAL: begin
						local_count_d = local_count_q + 8'd1;
						if (local_count_d == local_scan_ticks_q) begin
							m = rsaf_pkg::MODE_GLOBAL;
						end
					end
					default: ;
				endcase
			end

			// Then the mode reached acts on the sensors.
			case (m)
				rsaf_pkg::MODE_ESCAPE: begin
					cv = 1'b1;
					cl = rsaf_pkg::SPEED_ESCAPE;
					cr = rsaf_pkg::SPEED_ESCAPE;
				end
				rsaf_pkg::MODE_TURN: begin
					if (pair_now) begin
						m = rsaf_pkg::MODE_ATTACK;
					end else if (side_q == rsaf_pkg::SIDE_LEFT) begin
						cv = 1'b1;
						cl = -rsaf_pkg::SPEED_TURN;
						cr = rsaf_pkg::SPEED_TURN;
					end else begin
						cv = 1'b1;
						cl = rsaf_pkg::SPEED_TURN;
						cr = -rsaf_pkg::SPEED_TURN;
					end
				end
				rsaf_pkg::MODE_GLOBAL: begin
					if (item_s1.line_seen) begin
						escape_count_d = '0;
						m = rsaf_pkg::MODE_ESCAPE;
					end else if (persist) begin
						m = rsaf_pkg::MODE_ATTACK;
					end
					cv = 1'b1;
					cl = rsaf_pkg::SPEED_GLOBAL_LEFT;
					cr = rsaf_pkg::SPEED_GLOBAL_RIGHT;
				end
				rsaf_pkg::MODE_LOCAL: begin
					if (persist) begin
						m = rsaf_pkg::MODE_ATTACK;
					end else begin
						cv = 1'b1;
						case (side_q)
							rsaf_pkg::SIDE_LEFT: begin
								cl = -rsaf_pkg::SPEED_LOCAL;
								cr = '0;
							end
							rsaf_pkg::SIDE_RIGHT: begin
								cl = '0;
								cr = -rsaf_pkg::SPEED_LOCAL;
							end
							default: begin
								cl = -rsaf_pkg::SPEED_LOCAL;
								cr = -rsaf_pkg::SPEED_LOCAL;
							end
						endcase
					end
				end
				rsaf_pkg::MODE_ATTACK: begin
					if (item_s1.line_seen) begin
						escape_count_d = '0;
						m = rsaf_pkg::MODE_ESCAPE;
					end
					// The chase may still fall back to local scan after the line.
					if (cn) begin
						side_d = rsaf_pkg::SIDE_CENTER;
						cv = 1'b1;
						cl = -rsaf_pkg::SPEED_CHASE_CENTER;
						cr = -rsaf_pkg::SPEED_CHASE_CENTER;
					end else if (ln) begin
						side_d = rsaf_pkg::SIDE_LEFT;
						cv = 1'b1;
						cl = -rsaf_pkg::SPEED_CHASE_SIDE;
						cr = rsaf_pkg::SPEED_CHASE_SIDE;
					end else if (rn) begin
						side_d = rsaf_pkg::SIDE_RIGHT;
						cv = 1'b1;
						cl = rsaf_pkg::SPEED_CHASE_SIDE;
						cr = -rsaf_pkg::SPEED_CHASE_SIDE;
					end else if (!rp && !lp && !cp) begin
						local_count_d = '0;
						m = rsaf_pkg::MODE_LOCAL;
					end
				end
				default: ;
			endcase
		end

		mode_d               = m;
		result_d.speed_valid = cv;
		result_d.left_speed  = cl;
		result_d.right_speed = cr;
		result_d.mode        = m;
	end

	// Controller state advances with each item that reaches the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= rsaf_pkg::MODE_WAIT;
			side_q         <= rsaf_pkg::SIDE_CENTER;
			start_count_q  <= '0;
			turn_count_q   <= '0;
			escape_count_q <= '0;
			local_count_q  <= '0;
		end else if (advance) begin
			mode_q         <= mode_d;
			side_q         <= side_d;
			start_count_q  <= start_count_d;
			turn_count_q   <= turn_count_d;
			escape_count_q <= escape_count_d;
			local_count_q  <= local_count_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

endmodule

// File: rtl/core/rsaf_checker.sv
module rsaf_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  rsaf_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  rsaf_pkg::result_t result
);

	// A stalled result holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A result without a command carries zero speeds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.speed_valid |->
			result.left_speed == 8'sd0 && result.right_speed == 8'sd0)
		else $error("speeds not zero without a command");

	// The wait mode never commands the motors.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mode == rsaf_pkg::MODE_WAIT |-> !result.speed_valid)
		else $error("command issued in wait mode");

	// A pass that ends in the escape turn always commands a turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mode == rsaf_pkg::MODE_TURN |-> result.speed_valid)
		else $error("turn mode without a command");

	// An offered item stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("item changed while waiting");

endmodule

bind robot_seek_attack_fsm_top rsaf_checker u_rsaf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
